### rtl/core/aad_pkg.sv
// Shared types and constants for the area-average image downscaler.
// No dependencies; used by every module of the block except aad_ram.
`default_nettype none
package aad_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 1024;
   localparam int MAX_CHANNELS = 4;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int DIM_W        = 11;
   localparam int SUM_W        = 28;
   localparam int AREA_W       = 2 * DIM_W - 1;
   localparam int DIV_STEPS    = SUM_W;
   localparam int STEP_W       = $clog2(DIV_STEPS);

   localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
   localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
   localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
   localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
   localparam logic [2:0] REG_BPP        = 3'd4;

   typedef struct packed {
      logic [7:0] pixel_byte0;
      logic [7:0] pixel_byte1;
      logic [7:0] pixel_byte2;
      logic [7:0] pixel_byte3;
   } req_type;

   typedef struct packed {
      logic [7:0] avg_byte0;
      logic [7:0] avg_byte1;
      logic [7:0] avg_byte2;
      logic [7:0] avg_byte3;
      logic [9:0] out_col;
      logic [9:0] out_row;
      logic       frame_last;
   } rsp_type;

   typedef struct packed {
      logic init_start;
      logic init_load;
      logic accept;
      logic step;
      logic div_start;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic cfg_write;
      logic div_done;
      logic tile_done;
      logic out_free;
   } status_type;

   typedef enum logic [5:0] {
      ST_INIT      = 6'b000001,
      ST_INIT_WAIT = 6'b000010,
      ST_IDLE      = 6'b000100,
      ST_ACC       = 6'b001000,
      ST_DIV       = 6'b010000,
      ST_EMIT      = 6'b100000
   } state_type;

endpackage
`default_nettype wire

### rtl/core/area_average_image_downscaler.sv
// Top level of the area-average image downscaler.
// Depends on aad_pkg, aad_ctrl and aad_datapath.
//
// Source pixels enter on the req_ channel in raster order, one request per
// pixel; averaged output pixels leave on the rsp_ channel with their tile
// column, row and a frame_last flag. The csr_ port sets source size, output
// size and channel count; a write restarts the frame.
// A pixel that does not close a tile reads the column sum memory and then
// updates it. A pixel that closes a tile then passes through the shared
// restoring divider, and the output register is loaded with its response
// once free; no new request is taken until that load is done.
// After reset, and after each register write, the block computes the tile
// step with the same divider and holds req_stall high.
// The output register keeps its response while rsp_stall is high; further
// requests are taken meanwhile, and one that closes another tile holds the
// block after its division, with req_stall high, until the register frees.
`default_nettype none
module area_average_image_downscaler (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [4:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic      [31:0]      csr_prdata,
   output logic                  csr_pready,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire aad_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output aad_pkg::rsp_type      rsp_data
);
   aad_pkg::cmd_type    cmd;
   aad_pkg::status_type status;

   assign csr_pready = 1'b1;

   aad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   aad_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .status      (status)
   );
endmodule
`default_nettype wire

### rtl/core/aad_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module aad_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

### rtl/core/aad_div.sv
// Four-lane restoring divider, one quotient bit per lane per cycle.
// Depends on aad_pkg.
`default_nettype none
module aad_div (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   input  wire logic [3:0][aad_pkg::SUM_W-1:0]           dividend,
   input  wire logic [3:0][aad_pkg::AREA_W-1:0]          divisor,
   output logic                                          done,
   output logic      [3:0][aad_pkg::SUM_W-1:0]           quot,
   output logic      [3:0][aad_pkg::AREA_W-1:0]          rem
);
   logic [3:0][aad_pkg::SUM_W-1:0]  a_ff, a_in;
   logic [3:0][aad_pkg::AREA_W-1:0] r_ff, r_in, d_ff;
   logic [aad_pkg::STEP_W-1:0]      cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [aad_pkg::AREA_W:0]        t;

   always_comb begin
      a_in    = a_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      t       = '0;
      if (start) begin
         a_in    = dividend;
         r_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int k = 0; k < 4; k++) begin
            t = {r_ff[k], a_ff[k][aad_pkg::SUM_W-1]};
            if (t >= {1'b0, d_ff[k]}) begin
               r_in[k] = aad_pkg::AREA_W'(t - {1'b0, d_ff[k]});
               a_in[k] = {a_ff[k][aad_pkg::SUM_W-2:0], 1'b1};
            end else begin
               r_in[k] = t[aad_pkg::AREA_W-1:0];
               a_in[k] = {a_ff[k][aad_pkg::SUM_W-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == aad_pkg::STEP_W'(aad_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      a_ff <= a_in;
      r_ff <= r_in;
      if (start) begin
         d_ff <= divisor;
      end
   end

   assign done = done_ff;
   assign quot = a_ff;
   assign rem  = r_ff;
endmodule
`default_nettype wire

### rtl/core/aad_ctrl.sv
// Controller state machine: sequences setup, accumulation, division and emit.
// Depends on aad_pkg.
`default_nettype none
module aad_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire aad_pkg::status_type status,
   output aad_pkg::cmd_type         cmd
);
   aad_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         aad_pkg::ST_INIT: begin
            cmd.init_start = 1'b1;
            state_in       = aad_pkg::ST_INIT_WAIT;
         end
         aad_pkg::ST_INIT_WAIT: begin
            if (status.div_done) begin
               cmd.init_load = 1'b1;
               state_in      = aad_pkg::ST_IDLE;
            end
         end
         aad_pkg::ST_IDLE: begin
            req_stall = status.cfg_write;
            if (req_valid && !status.cfg_write) begin
               cmd.accept = 1'b1;
               state_in   = aad_pkg::ST_ACC;
            end
         end
         aad_pkg::ST_ACC: begin
            cmd.step = 1'b1;
            if (status.tile_done) begin
               cmd.div_start = 1'b1;
               state_in      = aad_pkg::ST_DIV;
            end else begin
               state_in = aad_pkg::ST_IDLE;
            end
         end
         aad_pkg::ST_DIV: begin
            if (status.div_done) begin
               state_in = aad_pkg::ST_EMIT;
            end
         end
         aad_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = aad_pkg::ST_IDLE;
            end
         end
         default: state_in = aad_pkg::ST_INIT;
      endcase
      if (status.cfg_write) begin
         state_in = aad_pkg::ST_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aad_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

### rtl/core/aad_datapath.sv
// Datapath: register file, tile bounds, column sum memory, divider, output register.
// Depends on aad_pkg, aad_ram and aad_div.
`default_nettype none
module aad_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [4:0]             csr_paddr,
   input  wire logic [31:0]            csr_pwdata,
   output logic      [31:0]            csr_prdata,
   input  wire aad_pkg::req_type       req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output aad_pkg::rsp_type            rsp_data,
   input  wire aad_pkg::cmd_type       cmd,
   output aad_pkg::status_type         status
);
   localparam int DW = aad_pkg::DIM_W;
   localparam int SW = aad_pkg::SUM_W;

   logic [DW-1:0] src_w_ff, src_h_ff, dst_w_ff, dst_h_ff;
   logic [2:0]    bpp_ff;
   logic [2:0]    idx;
   logic          wr;

   logic [DW-1:0] sw, sh, dw, dh;
   logic [2:0]    ch;
   logic          active;

   logic [DW-1:0] colq_ff, colr_ff, rowq_ff, rowr_ff;
   logic [DW-1:0] src_col_ff, src_col_in, src_row_ff, src_row_in;
   logic [aad_pkg::COL_W-1:0] tcol_ff, tcol_in, trow_ff, trow_in;
   logic [DW-1:0] cst_ff, cst_in, cend_ff, cend_in, crem_ff, crem_in;
   logic [DW-1:0] rst_ff, rst_in, rend_ff, rend_in, rrem_ff, rrem_in;
   logic [DW:0]   csum, rsum;

   aad_pkg::req_type px_ff;
   logic [2:0]       ch_ff;
   logic [3:0][SW-1:0] old_sums, new_sums;
   logic [4*SW-1:0]  rdata;
   logic             col_hit, row_hit, first;
   logic [aad_pkg::AREA_W-1:0] area;

   logic [3:0][SW-1:0]             dv_a, dv_q;
   logic [3:0][aad_pkg::AREA_W-1:0] dv_d, dv_r;
   logic                           dv_done;

   logic [9:0] mcol_ff, mrow_ff;
   logic       mlast_ff;
   logic       rsp_valid_ff;
   aad_pkg::rsp_type rsp_ff;

   assign idx = csr_paddr[4:2];
   assign wr  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= DW'(640);
         src_h_ff <= DW'(480);
         dst_w_ff <= DW'(320);
         dst_h_ff <= DW'(240);
         bpp_ff   <= 3'd3;
      end else if (wr) begin
         case (idx)
            aad_pkg::REG_SRC_WIDTH:  src_w_ff <= csr_pwdata[DW-1:0];
            aad_pkg::REG_SRC_HEIGHT: src_h_ff <= csr_pwdata[DW-1:0];
            aad_pkg::REG_DST_WIDTH:  dst_w_ff <= csr_pwdata[DW-1:0];
            aad_pkg::REG_DST_HEIGHT: dst_h_ff <= csr_pwdata[DW-1:0];
            aad_pkg::REG_BPP:        bpp_ff   <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         aad_pkg::REG_SRC_WIDTH:  csr_prdata = 32'(src_w_ff);
         aad_pkg::REG_SRC_HEIGHT: csr_prdata = 32'(src_h_ff);
         aad_pkg::REG_DST_WIDTH:  csr_prdata = 32'(dst_w_ff);
         aad_pkg::REG_DST_HEIGHT: csr_prdata = 32'(dst_h_ff);
         aad_pkg::REG_BPP:        csr_prdata = 32'(bpp_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   always_comb begin
      sw = (src_w_ff == '0) ? DW'(1) :
           (src_w_ff > DW'(aad_pkg::MAX_WIDTH)) ? DW'(aad_pkg::MAX_WIDTH) : src_w_ff;
      sh = (src_h_ff == '0) ? DW'(1) :
           (src_h_ff > DW'(aad_pkg::MAX_HEIGHT)) ? DW'(aad_pkg::MAX_HEIGHT) : src_h_ff;
      dw = (dst_w_ff < sw) ? dst_w_ff : sw;
      dh = (dst_h_ff < sh) ? dst_h_ff : sh;
      ch = (bpp_ff == '0) ? 3'd1 :
           (bpp_ff > 3'(aad_pkg::MAX_CHANNELS)) ? 3'(aad_pkg::MAX_CHANNELS) : bpp_ff;
      active = (dw != '0) && (dh != '0);
   end

   aad_ram #(.WIDTH(4 * SW), .DEPTH(aad_pkg::MAX_WIDTH)) u_sums (
      .clock (clock),
      .we    (cmd.step && active),
      .waddr (tcol_ff),
      .wdata (new_sums),
      .raddr (tcol_ff),
      .rdata (rdata)
   );

   always_comb begin
      old_sums = rdata;
      col_hit  = (src_col_ff + 1'b1) == cend_ff;
      row_hit  = (src_row_ff + 1'b1) == rend_ff;
      first    = (src_row_ff == rst_ff) && (src_col_ff == cst_ff);
      new_sums = old_sums;
      new_sums[0] = first ? SW'(px_ff.pixel_byte0) : old_sums[0] + SW'(px_ff.pixel_byte0);
      new_sums[1] = first ? SW'(px_ff.pixel_byte1) : old_sums[1] + SW'(px_ff.pixel_byte1);
      new_sums[2] = first ? SW'(px_ff.pixel_byte2) : old_sums[2] + SW'(px_ff.pixel_byte2);
      new_sums[3] = first ? SW'(px_ff.pixel_byte3) : old_sums[3] + SW'(px_ff.pixel_byte3);
      area = aad_pkg::AREA_W'((cend_ff - cst_ff) * (rend_ff - rst_ff));
   end

   always_comb begin
      if (cmd.init_start) begin
         dv_a = '0;
         dv_d = '0;
         dv_a[0] = SW'(sw);
         dv_d[0] = aad_pkg::AREA_W'(dw);
         dv_a[1] = SW'(sh);
         dv_d[1] = aad_pkg::AREA_W'(dh);
      end else begin
         dv_a = new_sums;
         for (int k = 0; k < 4; k++) begin
            dv_d[k] = area;
         end
      end
   end

   aad_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.init_start || cmd.div_start),
      .dividend (dv_a),
      .divisor  (dv_d),
      .done     (dv_done),
      .quot     (dv_q),
      .rem      (dv_r)
   );

   always_comb begin
      src_col_in = src_col_ff;
      src_row_in = src_row_ff;
      tcol_in    = tcol_ff;
      trow_in    = trow_ff;
      cst_in     = cst_ff;
      cend_in    = cend_ff;
      crem_in    = crem_ff;
      rst_in     = rst_ff;
      rend_in    = rend_ff;
      rrem_in    = rrem_ff;
      csum       = {1'b0, crem_ff} + {1'b0, colr_ff};
      rsum       = {1'b0, rrem_ff} + {1'b0, rowr_ff};
      if (cmd.init_load) begin
         src_col_in = '0;
         src_row_in = '0;
         tcol_in    = '0;
         trow_in    = '0;
         cst_in     = '0;
         rst_in     = '0;
         cend_in    = (dw == '0) ? '0 : dv_q[0][DW-1:0];
         crem_in    = (dw == '0) ? '0 : dv_r[0][DW-1:0];
         rend_in    = (dh == '0) ? '0 : dv_q[1][DW-1:0];
         rrem_in    = (dh == '0) ? '0 : dv_r[1][DW-1:0];
      end else if (cmd.step) begin
         if (active && col_hit) begin
            tcol_in = tcol_ff + 1'b1;
            cst_in  = cend_ff;
            if (csum >= {1'b0, dw}) begin
               cend_in = cend_ff + colq_ff + 1'b1;
               crem_in = DW'(csum - {1'b0, dw});
            end else begin
               cend_in = cend_ff + colq_ff;
               crem_in = csum[DW-1:0];
            end
         end
         if ((src_col_ff + 1'b1) >= sw) begin
            src_col_in = '0;
            tcol_in    = '0;
            cst_in     = '0;
            cend_in    = colq_ff;
            crem_in    = colr_ff;
            if (active && row_hit) begin
               trow_in = trow_ff + 1'b1;
               rst_in  = rend_ff;
               if (rsum >= {1'b0, dh}) begin
                  rend_in = rend_ff + rowq_ff + 1'b1;
                  rrem_in = DW'(rsum - {1'b0, dh});
               end else begin
                  rend_in = rend_ff + rowq_ff;
                  rrem_in = rsum[DW-1:0];
               end
            end
            if ((src_row_ff + 1'b1) >= sh) begin
               src_row_in = '0;
               trow_in    = '0;
               rst_in     = '0;
               rend_in    = rowq_ff;
               rrem_in    = rowr_ff;
            end else begin
               src_row_in = src_row_ff + 1'b1;
            end
         end else begin
            src_col_in = src_col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff <= '0;
         src_row_ff <= '0;
         tcol_ff    <= '0;
         trow_ff    <= '0;
         cst_ff     <= '0;
         cend_ff    <= '0;
         crem_ff    <= '0;
         rst_ff     <= '0;
         rend_ff    <= '0;
         rrem_ff    <= '0;
         colq_ff    <= '0;
         colr_ff    <= '0;
         rowq_ff    <= '0;
         rowr_ff    <= '0;
      end else begin
         src_col_ff <= src_col_in;
         src_row_ff <= src_row_in;
         tcol_ff    <= tcol_in;
         trow_ff    <= trow_in;
         cst_ff     <= cst_in;
         cend_ff    <= cend_in;
         crem_ff    <= crem_in;
         rst_ff     <= rst_in;
         rend_ff    <= rend_in;
         rrem_ff    <= rrem_in;
         if (cmd.init_load) begin
            colq_ff <= cend_in;
            colr_ff <= crem_in;
            rowq_ff <= rend_in;
            rowr_ff <= rrem_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         px_ff <= req_data;
         ch_ff <= ch;
      end
      if (cmd.div_start) begin
         mcol_ff  <= tcol_ff;
         mrow_ff  <= trow_ff;
         mlast_ff <= ((11'(tcol_ff) + 1'b1) == dw) && ((11'(trow_ff) + 1'b1) == dh);
      end
   end

   assign status.cfg_write = wr && (idx <= aad_pkg::REG_BPP);
   assign status.div_done  = dv_done;
   assign status.tile_done = active && col_hit && row_hit;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_ff.avg_byte0  <= dv_q[0][7:0];
         rsp_ff.avg_byte1  <= (ch_ff > 3'd1) ? dv_q[1][7:0] : 8'd0;
         rsp_ff.avg_byte2  <= (ch_ff > 3'd2) ? dv_q[2][7:0] : 8'd0;
         rsp_ff.avg_byte3  <= (ch_ff > 3'd3) ? dv_q[3][7:0] : 8'd0;
         rsp_ff.out_col    <= mcol_ff;
         rsp_ff.out_row    <= mrow_ff;
         rsp_ff.frame_last <= mlast_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire
